@@ hw/rtl/amt_pkg.sv @@
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants of the adaptive mean threshold block.
// ----------------------------------------------------------------------------
package amt_pkg;

  localparam int unsigned MaxHeight = 2048;
  localparam int unsigned RowW      = 11;
  localparam int unsigned PixW      = 8;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_KERNEL = 3'd0,
    REG_OFFSET = 3'd1,
    REG_HIGH   = 3'd2,
    REG_LOW    = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]  kernel_size;
    logic [8:0]  offset;
    logic [7:0]  high_value;
    logic [7:0]  low_value;
    logic [11:0] image_width;
    logic [11:0] image_height;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_WINDOW,
    ST_DRAIN,
    ST_DIV,
    ST_OUT_I,
    ST_OUT_B
  } back_state_e;

endpackage

@@ hw/rtl/adaptive_mean_threshold.sv @@
// ----------------------------------------------------------------------------
// adaptive_mean_threshold
// Local mean threshold of a grey raster stream over a square box window.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (in_valid_i / in_stall_o) in raster order.
// Each pixel gives zero, one or two beats on the out channel: first the
// interior pixel whose window it completes, then the pixel itself if it
// lies on the border. Every beat carries row, column, value and flags.
// The front writes each pixel to the line store and queues a job in the
// cycle it is taken; a two-entry queue lets it run ahead of the back.
// The back reads the window one pixel per cycle from the single read port
// of the line store, then divides by k*k one quotient bit per cycle.
// A pixel that completes a window takes the longest: the single read
// port and the divider set the pace. The sum and the quotient are SW
// bits wide (16 bits at the default kernel bound), and a job may also
// wait in the queue before the back takes it.
// Reset clears the raster counters, the queue and the result valid flag;
// the line store is not cleared. While out_stall_i is high a result beat
// holds, the back halts at its next beat, the queue takes pixels till full.
// Registers sit on an APB port at byte addresses 4*i, pready always high.
// ----------------------------------------------------------------------------
module adaptive_mean_threshold #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_KERNEL = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [amt_pkg::AddrW-1:0]     paddr,
  input  logic [amt_pkg::DataW-1:0]     pwdata,
  output logic [amt_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [10:0]                   out_row_o,
  output logic [10:0]                   out_column_o,
  output logic [7:0]                    out_value_o,
  output logic                          is_border_o,
  output logic                          run_last_o,
  output logic                          frame_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned JOB_W = amt_pkg::RowW + CW + RW + amt_pkg::PixW + 3;

  amt_pkg::cfg_t      cfg_q;
  amt_pkg::reg_idx_e  idx;
  logic               wr;

  logic               push, pop, full, not_empty;
  logic [JOB_W-1:0]   job_in, job_head;
  logic               wr_en, rd_en;
  logic [RW+CW-1:0]   wr_addr, rd_addr;
  logic [7:0]         rd_data;

  assign pready = 1'b1;
  assign idx    = amt_pkg::reg_idx_e'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_size  <= 4'd3;
      cfg_q.offset       <= 9'd0;
      cfg_q.high_value   <= 8'd255;
      cfg_q.low_value    <= 8'd0;
      cfg_q.image_width  <= 12'd640;
      cfg_q.image_height <= 12'd480;
    end else if (wr) begin
      case (idx)
        amt_pkg::REG_KERNEL: cfg_q.kernel_size  <= pwdata[3:0];
        amt_pkg::REG_OFFSET: cfg_q.offset       <= pwdata[8:0];
        amt_pkg::REG_HIGH:   cfg_q.high_value   <= pwdata[7:0];
        amt_pkg::REG_LOW:    cfg_q.low_value    <= pwdata[7:0];
        amt_pkg::REG_WIDTH:  cfg_q.image_width  <= pwdata[11:0];
        amt_pkg::REG_HEIGHT: cfg_q.image_height <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      amt_pkg::REG_KERNEL: prdata = 32'(cfg_q.kernel_size);
      amt_pkg::REG_OFFSET: prdata = 32'(cfg_q.offset);
      amt_pkg::REG_HIGH:   prdata = 32'(cfg_q.high_value);
      amt_pkg::REG_LOW:    prdata = 32'(cfg_q.low_value);
      amt_pkg::REG_WIDTH:  prdata = 32'(cfg_q.image_width);
      amt_pkg::REG_HEIGHT: prdata = 32'(cfg_q.image_height);
      default:             prdata = '0;
    endcase
  end

  assign in_stall_o = full;

  amt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .pixel_i     (pixel_i),
    .fifo_full_i (full),
    .push_o      (push),
    .job_o       (job_in),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr)
  );

  amt_fifo #(
    .DATA_W (JOB_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (job_in),
    .pop_i       (pop),
    .head_o      (job_head),
    .full_o      (full),
    .not_empty_o (not_empty)
  );

  amt_line_store #(
    .AW (RW + CW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (pixel_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  amt_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (not_empty),
    .job_i        (job_head),
    .pop_o        (pop),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .out_value_o  (out_value_o),
    .is_border_o  (is_border_o),
    .run_last_o   (run_last_o),
    .frame_last_o (frame_last_o)
  );

endmodule

@@ hw/rtl/amt_line_store.sv @@
// ----------------------------------------------------------------------------
// amt_line_store
// Ring of image rows: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module amt_line_store #(
  parameter int unsigned AW = 15
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [amt_pkg::PixW-1:0]  wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [amt_pkg::PixW-1:0]  rd_data_o
);

  logic [amt_pkg::PixW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

@@ hw/rtl/amt_fifo.sv @@
// ----------------------------------------------------------------------------
// amt_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module amt_fifo #(
  parameter int unsigned DATA_W = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] head_o,
  output logic              full_o,
  output logic              not_empty_o
);

  logic [DATA_W-1:0] mem_q [2];
  logic              wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]        cnt_q, cnt_d;

  assign full_o      = (cnt_q == 2'd2);
  assign not_empty_o = (cnt_q != 2'd0);
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/amt_front.sv @@
// ----------------------------------------------------------------------------
// amt_front
// Accepts pixels, tracks raster position, writes the line store and
// classifies each pixel into a job for the back.
// ----------------------------------------------------------------------------
module amt_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_KERNEL = 15,
  localparam int unsigned CW     = $clog2(MAX_WIDTH),
  localparam int unsigned WW     = $clog2(MAX_WIDTH + 1),
  localparam int unsigned Ring   = MAX_KERNEL + 1,
  localparam int unsigned RW     = $clog2(Ring),
  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1),
  localparam int unsigned JOB_W  = amt_pkg::RowW + CW + RW + amt_pkg::PixW + 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  amt_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  input  logic [amt_pkg::PixW-1:0]  pixel_i,
  input  logic                      fifo_full_i,
  output logic                      push_o,
  output logic [JOB_W-1:0]          job_o,
  output logic                      wr_en_o,
  output logic [RW+CW-1:0]          wr_addr_o
);

  typedef struct packed {
    logic [amt_pkg::RowW-1:0] row;
    logic [CW-1:0]            col;
    logic [RW-1:0]            ring;
    logic [amt_pkg::PixW-1:0] pixel;
    logic                     interior;
    logic                     border;
    logic                     last;
  } job_t;

  logic [amt_pkg::RowW-1:0] row_q, row_d;
  logic [CW-1:0]            col_q, col_d;
  logic [RW-1:0]            ring_q, ring_d;

  logic [KW-1:0]            k;
  logic [KW-1:0]            h;
  logic [KW-1:0]            span;
  logic [WW-1:0]            w;
  logic [11:0]              hgt;
  logic [amt_pkg::RowW-1:0] r;
  logic [CW-1:0]            c;
  logic [RW-1:0]            ring;
  logic [12:0]              r_ext;
  logic [WW:0]              c_ext;
  logic                     accept;
  job_t                     job;

  assign accept = in_valid_i && !fifo_full_i;

  always_comb begin
    if (cfg_i.kernel_size == 4'd0) begin
      k = KW'(1);
    end else if (32'(cfg_i.kernel_size) > MAX_KERNEL) begin
      k = KW'(MAX_KERNEL);
    end else begin
      k = KW'(cfg_i.kernel_size);
    end
    if (cfg_i.image_width == 12'd0) begin
      w = WW'(1);
    end else if (32'(cfg_i.image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_i.image_width);
    end
    if (cfg_i.image_height == 12'd0) begin
      hgt = 12'd1;
    end else if (32'(cfg_i.image_height) > amt_pkg::MaxHeight) begin
      hgt = 12'(amt_pkg::MaxHeight);
    end else begin
      hgt = cfg_i.image_height;
    end
  end

  assign h    = k >> 1;
  assign span = h << 1;

  // restart the frame when the counters fall outside a changed frame size
  always_comb begin
    if ((12'(row_q) >= hgt) || ((WW+1)'(col_q) >= (WW+1)'(w))) begin
      r    = '0;
      c    = '0;
      ring = '0;
    end else begin
      r    = row_q;
      c    = col_q;
      ring = ring_q;
    end
    r_ext = 13'(r);
    c_ext = (WW+1)'(c);
  end

  always_comb begin
    job.row      = r;
    job.col      = c;
    job.ring     = ring;
    job.pixel    = pixel_i;
    job.interior = (r_ext >= 13'(span)) && (c_ext >= (WW+1)'(span));
    job.border   = (r_ext < 13'(h)) || (c_ext < (WW+1)'(h)) ||
                   (r_ext + 13'(h) >= 13'(hgt)) || (c_ext + (WW+1)'(h) >= (WW+1)'(w));
    job.last     = (r_ext + 13'd1 == 13'(hgt)) && (c_ext + 1'b1 == (WW+1)'(w));
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    ring_d = ring_q;
    if (accept) begin
      if (c_ext + 1'b1 >= (WW+1)'(w)) begin
        col_d = '0;
        if (r_ext + 13'd1 >= 13'(hgt)) begin
          row_d  = '0;
          ring_d = '0;
        end else begin
          row_d  = r + 1'b1;
          ring_d = (32'(ring) == Ring - 1) ? '0 : ring + 1'b1;
        end
      end else begin
        row_d  = r;
        ring_d = ring;
        col_d  = c + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      ring_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      ring_q <= ring_d;
    end
  end

  assign push_o    = accept;
  assign job_o     = job;
  assign wr_en_o   = accept;
  assign wr_addr_o = {ring, c};

endmodule

@@ hw/rtl/amt_back.sv @@
// ----------------------------------------------------------------------------
// amt_back
// Sums the window from the line store, divides by k*k one bit per cycle,
// thresholds the centre pixel, passes border pixels and loads the result beat.
// ----------------------------------------------------------------------------
module amt_back #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_KERNEL = 15,
  localparam int unsigned CW     = $clog2(MAX_WIDTH),
  localparam int unsigned Ring   = MAX_KERNEL + 1,
  localparam int unsigned RW     = $clog2(Ring),
  localparam int unsigned KW     = $clog2(MAX_KERNEL + 1),
  localparam int unsigned SW     = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1),
  localparam int unsigned DCW    = $clog2(SW + 1),
  localparam int unsigned JOB_W  = amt_pkg::RowW + CW + RW + amt_pkg::PixW + 3
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  amt_pkg::cfg_t             cfg_i,
  input  logic                      job_valid_i,
  input  logic [JOB_W-1:0]          job_i,
  output logic                      pop_o,
  output logic                      rd_en_o,
  output logic [RW+CW-1:0]          rd_addr_o,
  input  logic [amt_pkg::PixW-1:0]  rd_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [10:0]               out_row_o,
  output logic [10:0]               out_column_o,
  output logic [7:0]                out_value_o,
  output logic                      is_border_o,
  output logic                      run_last_o,
  output logic                      frame_last_o
);

  typedef struct packed {
    logic [amt_pkg::RowW-1:0] row;
    logic [CW-1:0]            col;
    logic [RW-1:0]            ring;
    logic [amt_pkg::PixW-1:0] pixel;
    logic                     interior;
    logic                     border;
    logic                     last;
  } job_t;

  amt_pkg::back_state_e state_q, state_d;

  job_t                      head, job_q;
  logic [RW-1:0]             ring_q;
  logic [CW-1:0]             col_q;
  logic [KW-1:0]             icnt_q, jcnt_q;
  logic                      rd_ctr_q, rd_win_q;
  logic [7:0]                centre_q;
  logic [SW-1:0]             acc_q, quo_q;
  logic [2*KW:0]             rem_q;
  logic [DCW-1:0]            dcnt_q;

  logic [KW-1:0]             k, h, span;
  logic [2*KW-1:0]           kk;
  logic [RW:0]               rsum;
  logic [RW-1:0]             ctr_ring;
  logic [CW-1:0]             ctr_col;
  logic [2*KW:0]             trial;
  logic signed [SW+1:0]      thr, ctr_ext;
  logic                      out_free, load_out, out_valid_q;

  assign head = job_i;

  always_comb begin
    if (cfg_i.kernel_size == 4'd0) begin
      k = KW'(1);
    end else if (32'(cfg_i.kernel_size) > MAX_KERNEL) begin
      k = KW'(MAX_KERNEL);
    end else begin
      k = KW'(cfg_i.kernel_size);
    end
  end

  assign h    = k >> 1;
  assign span = h << 1;
  assign kk   = (2*KW)'(k) * (2*KW)'(k);

  // ring row of the centre, wrapping below row zero of the ring
  assign rsum     = (RW+1)'(job_q.ring) + (RW+1)'(Ring) - (RW+1)'(h);
  assign ctr_ring = (32'(rsum) >= Ring) ? RW'(32'(rsum) - Ring) : RW'(rsum);
  assign ctr_col  = job_q.col - CW'(h);

  assign trial   = {rem_q[2*KW-1:0], quo_q[SW-1]};
  assign thr     = signed'((SW+2)'(quo_q)) - (SW+2)'($signed(cfg_i.offset));
  assign ctr_ext = signed'((SW+2)'(centre_q));

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      amt_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          if (head.interior) begin
            state_d = amt_pkg::ST_CENTRE;
          end else if (head.border) begin
            state_d = amt_pkg::ST_OUT_B;
          end
        end
      end
      amt_pkg::ST_CENTRE: state_d = amt_pkg::ST_WINDOW;
      amt_pkg::ST_WINDOW: begin
        if (icnt_q == span && jcnt_q == span) begin
          state_d = amt_pkg::ST_DRAIN;
        end
      end
      amt_pkg::ST_DRAIN: state_d = amt_pkg::ST_DIV;
      amt_pkg::ST_DIV: begin
        if (dcnt_q == DCW'(1)) begin
          state_d = amt_pkg::ST_OUT_I;
        end
      end
      amt_pkg::ST_OUT_I: begin
        if (out_free) begin
          state_d = job_q.border ? amt_pkg::ST_OUT_B : amt_pkg::ST_IDLE;
        end
      end
      amt_pkg::ST_OUT_B: begin
        if (out_free) begin
          state_d = amt_pkg::ST_IDLE;
        end
      end
      default: state_d = amt_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = {ring_q, col_q};
    load_out  = 1'b0;
    case (state_q)
      amt_pkg::ST_IDLE:   pop_o = job_valid_i;
      amt_pkg::ST_CENTRE: begin
        rd_en_o   = 1'b1;
        rd_addr_o = {ctr_ring, ctr_col};
      end
      amt_pkg::ST_WINDOW: rd_en_o = 1'b1;
      amt_pkg::ST_OUT_I,
      amt_pkg::ST_OUT_B:  load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= amt_pkg::ST_IDLE;
      rd_ctr_q    <= 1'b0;
      rd_win_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_ctr_q <= (state_q == amt_pkg::ST_CENTRE);
      rd_win_q <= (state_q == amt_pkg::ST_WINDOW);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q  <= head;
      ring_q <= head.ring;
      col_q  <= head.col;
      icnt_q <= '0;
      jcnt_q <= '0;
      acc_q  <= '0;
    end
    if (rd_ctr_q) begin
      centre_q <= rd_data_i;
    end
    if (rd_win_q) begin
      acc_q <= acc_q + SW'(rd_data_i);
    end
    // walk the window right to left, then one row up the ring
    if (state_q == amt_pkg::ST_WINDOW) begin
      if (jcnt_q == span) begin
        jcnt_q <= '0;
        col_q  <= job_q.col;
        icnt_q <= icnt_q + 1'b1;
        ring_q <= (ring_q == '0) ? RW'(Ring - 1) : ring_q - 1'b1;
      end else begin
        jcnt_q <= jcnt_q + 1'b1;
        col_q  <= col_q - 1'b1;
      end
    end
    if (state_q == amt_pkg::ST_DRAIN) begin
      quo_q  <= acc_q + SW'(rd_data_i);
      rem_q  <= '0;
      dcnt_q <= DCW'(SW);
    end
    if (state_q == amt_pkg::ST_DIV) begin
      dcnt_q <= dcnt_q - 1'b1;
      if (trial >= (2*KW+1)'(kk)) begin
        rem_q <= trial - (2*KW+1)'(kk);
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
    if (load_out) begin
      if (state_q == amt_pkg::ST_OUT_I) begin
        out_row_o    <= job_q.row - 11'(h);
        out_column_o <= 11'(job_q.col - CW'(h));
        out_value_o  <= (ctr_ext > thr) ? cfg_i.high_value : cfg_i.low_value;
        is_border_o  <= 1'b0;
        run_last_o   <= !job_q.border;
        frame_last_o <= !job_q.border && job_q.last;
      end else begin
        out_row_o    <= job_q.row;
        out_column_o <= 11'(job_q.col);
        out_value_o  <= job_q.pixel;
        is_border_o  <= 1'b1;
        run_last_o   <= 1'b1;
        frame_last_o <= job_q.last;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/amt_checker.sv @@
// ----------------------------------------------------------------------------
// amt_checker
// Port-level checks of the adaptive mean threshold block.
// ----------------------------------------------------------------------------
module amt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [10:0] out_row_o,
  input logic [10:0] out_column_o,
  input logic [7:0]  out_value_o,
  input logic        is_border_o,
  input logic        run_last_o,
  input logic        frame_last_o
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o) &&
                                   $stable(out_row_o) && $stable(out_column_o))
    else $error("result beat changed while stalled");

  // the frame ends only on the last beat of a pixel
  a_frame_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> run_last_o)
    else $error("frame_last without run_last");

  // a border beat always closes its pixel
  a_border_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_border_o |-> run_last_o)
    else $error("border beat not last of its pixel");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind adaptive_mean_threshold amt_checker u_amt_checker (.*);
